>>> design/rsp_pkg.sv
// Shared types, constants and register codes for the random eviction shuffle pool.
package rsp_pkg;

    // Fixed field widths of the stream and register interface.
    localparam int ROW_OUT_W   = 64;
    localparam int RAND_W      = 10;
    localparam int CFG_W       = 11;
    localparam int BATCH_W     = 10;
    localparam int IN_TDATA_W  = 80;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // Defaults for the top-level parameters.
    localparam int DEF_POOL_DEPTH = 1024;
    localparam int DEF_ROW_BITS   = 64;

    // Register reset values and batch size bounds.
    localparam logic [CFG_W-1:0] POOL_LIMIT_RST = 11'd1024;
    localparam logic [CFG_W-1:0] BATCH_SIZE_RST = 11'd256;
    localparam logic [CFG_W-1:0] BATCH_MAX      = 11'd1024;

    // Register indexes on the configuration port.
    localparam logic REG_POOL_LIMIT = 1'b0;
    localparam logic REG_BATCH_SIZE = 1'b1;

    // Request kinds carried in the input tuser.
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EVICT,
        S_DRAIN,
        S_MOVE
    } t_state;

    // What an incoming request turns into.
    typedef enum logic [1:0] {
        CLS_SKIP,
        CLS_STORE,
        CLS_EVICT,
        CLS_DRAIN
    } t_cls;

    // Configuration register contents.
    typedef struct packed {
        logic [CFG_W-1:0] pool_limit;
        logic [CFG_W-1:0] batch_size;
    } t_cfg;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cls cls;
        logic out_free;
    } t_stat;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic store;
        logic rd_pick;
        logic emit_evict;
        logic emit_drain;
        logic move;
    } t_cmd;

endpackage

>>> design/rsp_ctrl.sv
// Controller state machine that sequences pool memory accesses per request.
module rsp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  rsp_pkg::t_stat i_stat,
    output logic          o_ready,
    output rsp_pkg::t_cmd  o_cmd
);
    import rsp_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_stat.cls)
                        CLS_EVICT: n_state = S_EVICT;
                        CLS_DRAIN: n_state = S_DRAIN;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_EVICT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_DRAIN: begin
                if (i_stat.out_free) n_state = S_MOVE;
            end
            S_MOVE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready        = 1'b1;
                o_cmd.accept   = i_valid;
                o_cmd.store    = i_valid && (i_stat.cls == CLS_STORE);
                o_cmd.rd_pick  = i_valid &&
                                 ((i_stat.cls == CLS_EVICT) || (i_stat.cls == CLS_DRAIN));
            end
            S_EVICT: begin
                o_cmd.emit_evict = i_stat.out_free;
            end
            S_DRAIN: begin
                o_cmd.emit_drain = i_stat.out_free;
            end
            S_MOVE: begin
                o_cmd.move = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // A result is only produced when the output register can take it.
    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_evict || o_cmd.emit_drain) |-> i_stat.out_free)
        else $error("result produced while output register is occupied");

    // A drain step always moves a row back in the cycle after its result.
    a_drain_then_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_drain |=> o_cmd.move)
        else $error("drain result not followed by the row move");

    // Nothing is accepted while a request is still in progress.
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.move || o_cmd.emit_evict) |-> !o_cmd.accept)
        else $error("request accepted while another is in progress");

endmodule

>>> design/rsp_dp.sv
// Datapath: pool memory, fill and batch counters, pick clamping and output register.
module rsp_dp #(
    parameter int POOL_DEPTH = rsp_pkg::DEF_POOL_DEPTH,
    parameter int ROW_BITS   = rsp_pkg::DEF_ROW_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rsp_pkg::t_cfg                  i_cfg,
    input  logic                           i_kind,
    input  logic [rsp_pkg::ROW_OUT_W-1:0]  i_row_data,
    input  logic [rsp_pkg::RAND_W-1:0]     i_rand_value,
    input  rsp_pkg::t_cmd                  i_cmd,
    output rsp_pkg::t_stat                 o_stat,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [rsp_pkg::ROW_OUT_W-1:0]  o_row_out,
    output logic                           o_batch_end,
    output logic                           o_pool_empty
);
    import rsp_pkg::*;

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int WW = (CW > CFG_W) ? CW : CFG_W;

    // Pool memory, single port with registered read data.
    logic [ROW_BITS-1:0] r_mem [POOL_DEPTH];
    logic [ROW_BITS-1:0] r_rd_data;
    logic                mem_we;
    logic                mem_re;
    logic [AW-1:0]       mem_addr;
    logic [ROW_BITS-1:0] mem_wdata;

    // Control and item registers.
    logic [CW-1:0]       r_fill;
    logic [BATCH_W-1:0]  r_batch;
    logic                r_draining;
    logic [AW-1:0]       r_pick;
    logic [ROW_BITS-1:0] r_data;
    logic                r_last;

    // Output register.
    logic                r_out_valid;
    logic [ROW_BITS-1:0] r_out_row;
    logic                r_out_last;
    logic                r_out_empty;

    logic [WW-1:0]       lim_raw;
    logic [WW-1:0]       eff_lim;
    logic [WW-1:0]       fill_w;
    logic [WW-1:0]       rnd_w;
    logic [WW-1:0]       bound;
    logic [WW-1:0]       pick_w;
    logic [CFG_W-1:0]    eff_batch;
    logic [CFG_W-1:0]    batch_next;
    logic                batch_done;
    logic                emit;
    logic [AW-1:0]       last_addr;

    // Effective pool limit, clamped into one to POOL_DEPTH.
    always_comb begin
        lim_raw = WW'(i_cfg.pool_limit);
        if (lim_raw == '0) begin
            eff_lim = WW'(1);
        end else if (lim_raw > WW'(POOL_DEPTH)) begin
            eff_lim = WW'(POOL_DEPTH);
        end else begin
            eff_lim = lim_raw;
        end
    end

    // Random pick clamped below the limit for adds or the fill for drains.
    always_comb begin
        fill_w = WW'(r_fill);
        rnd_w  = WW'(i_rand_value);
        bound  = (i_kind == KIND_ADD) ? eff_lim : fill_w;
        pick_w = (rnd_w >= bound) ? (bound - WW'(1)) : rnd_w;
    end

    // Request classification.
    always_comb begin
        if (i_kind == KIND_ADD) begin
            if (r_draining) begin
                o_stat.cls = CLS_SKIP;
            end else if (fill_w < eff_lim) begin
                o_stat.cls = CLS_STORE;
            end else begin
                o_stat.cls = CLS_EVICT;
            end
        end else begin
            o_stat.cls = (r_fill == '0) ? CLS_SKIP : CLS_DRAIN;
        end
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    // Batch counting on each emitted row.
    always_comb begin
        if (i_cfg.batch_size == '0) begin
            eff_batch = CFG_W'(1);
        end else if (i_cfg.batch_size > BATCH_MAX) begin
            eff_batch = BATCH_MAX;
        end else begin
            eff_batch = i_cfg.batch_size;
        end
        batch_next = CFG_W'(r_batch) + CFG_W'(1);
        batch_done = (i_cmd.emit_drain && r_last) || (batch_next >= eff_batch);
        emit       = i_cmd.emit_evict || i_cmd.emit_drain;
        last_addr  = AW'(r_fill - CW'(1));
    end

    // Memory address and data selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = r_pick;
        mem_wdata = r_data;
        if (i_cmd.store) begin
            mem_we    = 1'b1;
            mem_addr  = AW'(r_fill);
            mem_wdata = i_row_data[ROW_BITS-1:0];
        end else if (i_cmd.rd_pick) begin
            mem_re   = 1'b1;
            mem_addr = AW'(pick_w);
        end else if (i_cmd.emit_evict) begin
            mem_we = 1'b1;
        end else if (i_cmd.emit_drain) begin
            mem_re   = 1'b1;
            mem_addr = last_addr;
        end else if (i_cmd.move) begin
            mem_we    = 1'b1;
            mem_wdata = r_rd_data;
        end
    end

    // Pool memory access.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    // Item capture on acceptance.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pick <= AW'(pick_w);
            r_data <= i_row_data[ROW_BITS-1:0];
            r_last <= (r_fill == CW'(1));
        end
    end

    // Fill count, batch count and draining flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_batch    <= '0;
            r_draining <= 1'b0;
        end else begin
            if (i_cmd.accept && (i_kind == KIND_DRAIN)) begin
                r_draining <= 1'b1;
            end
            if (i_cmd.store) begin
                r_fill <= r_fill + CW'(1);
            end else if (i_cmd.move) begin
                r_fill <= r_fill - CW'(1);
            end
            if (emit) begin
                r_batch <= batch_done ? '0 : batch_next[BATCH_W-1:0];
            end
        end
    end

    // Output register, loaded with the row read from the pool.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_row   <= r_rd_data;
            r_out_last  <= batch_done;
            r_out_empty <= i_cmd.emit_drain && r_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_row_out    = ROW_OUT_W'(r_out_row);
    assign o_batch_end  = r_out_last;
    assign o_pool_empty = r_out_empty;

    // The fill count never passes the pool depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(POOL_DEPTH))
        else $error("fill count beyond pool depth");

    // No row is stored once draining has started.
    a_no_store_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> !r_draining)
        else $error("row stored after draining started");

    // A drain step removes exactly one row.
    a_move_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.move |=> (r_fill == $past(r_fill) - CW'(1)))
        else $error("fill count not decremented by a drain step");

endmodule

>>> design/random_eviction_shuffle_pool_unit.sv
// Stores a pool of rows and emits them in random order on eviction and drain.
// Requests are handled one at a time, as set by the single-port pool memory: an eviction
// reads the picked row, then writes the new row in its place; a drain step reads the picked
// row, then the last row, then moves the last row into the picked slot.
// Reset is synchronous and active low: it clears counts, draining, output valid
// and restores register defaults; the pool memory is not cleared.
module random_eviction_shuffle_pool_unit #(
    parameter int POOL_DEPTH = rsp_pkg::DEF_POOL_DEPTH,
    parameter int ROW_BITS   = rsp_pkg::DEF_ROW_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rsp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // row_data[63:0], rand_value[73:64]
    input  logic                            s_axis_tuser,  // kind
    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rsp_pkg::ROW_OUT_W-1:0]   m_axis_tdata,  // row_out[63:0]
    output logic                            m_axis_tlast,  // batch_end
    output logic                            m_axis_tuser,  // pool_empty
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rsp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rsp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rsp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import rsp_pkg::*;

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;
    logic  cfg_wr;
    logic  reg_idx;

    // Register write decode.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pool_limit <= POOL_LIMIT_RST;
            r_cfg.batch_size <= BATCH_SIZE_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_POOL_LIMIT: r_cfg.pool_limit <= pwdata[CFG_W-1:0];
                REG_BATCH_SIZE: r_cfg.batch_size <= pwdata[CFG_W-1:0];
                default:        r_cfg <= r_cfg;
            endcase
        end
    end

    // Register read.
    always_comb begin
        unique case (reg_idx)
            REG_POOL_LIMIT: prdata = APB_DATA_W'(r_cfg.pool_limit);
            REG_BATCH_SIZE: prdata = APB_DATA_W'(r_cfg.batch_size);
            default:        prdata = '0;
        endcase
    end

    // Request sequencing.
    rsp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_stat  (stat),
        .o_ready (s_axis_tready),
        .o_cmd   (cmd)
    );

    // Pool storage and result formation.
    rsp_dp #(
        .POOL_DEPTH (POOL_DEPTH),
        .ROW_BITS   (ROW_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_kind       (s_axis_tuser),
        .i_row_data   (s_axis_tdata[ROW_OUT_W-1:0]),
        .i_rand_value (s_axis_tdata[ROW_OUT_W+RAND_W-1:ROW_OUT_W]),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_row_out    (m_axis_tdata),
        .o_batch_end  (m_axis_tlast),
        .o_pool_empty (m_axis_tuser)
    );

endmodule
